[design/c3rb_pkg.sv]
// Types and constants shared by the 3x3 replicate-border convolution unit.
// No dependencies.

package c3rb_pkg;

    localparam int PIX_W          = 8;
    localparam int PIX_MAX        = 255;
    localparam int TAP_W          = 16;
    localparam int CFG_W          = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int GEOM_W         = 12;
    localparam int ROW_OUT_W      = 11;
    localparam int HEIGHT_MAX     = 2048;
    localparam int COEF_FRAC_BITS = 8;
    localparam int PROD_W         = 25;
    localparam int RSUM_W         = 27;
    localparam int SUM_W          = 28;

    localparam logic [CFG_W-1:0]  COEF_RESET   = 48'hFF00_0000_0100;
    localparam logic [GEOM_W-1:0] WIDTH_RESET  = 12'd512;
    localparam logic [GEOM_W-1:0] HEIGHT_RESET = 12'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_TOP     = 3'd0,
        CFG_COEF_MID     = 3'd1,
        CFG_COEF_BOT     = 3'd2,
        CFG_FRAME_WIDTH  = 3'd3,
        CFG_FRAME_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [PIX_W-1:0] pixel_in;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } t_out_word;

    // position flags of the output pixel, carried with each word
    typedef struct packed {
        logic c_first;
        logic c_last;
        logic r_first;
        logic r_last;
        logic last;
    } t_win_ctl;

    // one column of three pixels: [0] top, [1] middle, [2] bottom
    typedef logic [2:0][PIX_W-1:0] t_col;

endpackage

[design/conv3x3_replicate_border_unit.sv]
// 3x3 convolution with replicated border over an 8-bit raster pixel stream.
// Depends on c3rb_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
//   cycle while o_in_ready is high: pixel words in raster order, then flush
//   words to drain the frame. Output k of a frame leaves on input word
//   k+width+1 and shows on o_out_valid / o_out_word after stages 1 to 5 and
//   the output register. Throughput is one word per cycle unless the output
//   stalls; the line memory is read once per word, written once per pixel word.
//   A flush word before the frame's pixels are all in is taken and dropped;
//   a pixel word after them acts as a flush. frame_last marks the final
//   pixel, after which the counters restart for the next frame.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while the block is idle; writing width or height restarts the frame.
//   Reset loads the default kernel and a 512x512 geometry and clears the
//   counters and pipeline; the line memory is not cleared, since every row
//   is rewritten before it is used.
//   When the receiver stalls, the pipeline fills and o_in_ready drops once
//   no stage is free.

module conv3x3_replicate_border_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  c3rb_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output c3rb_pkg::t_out_word              o_out_word,
    input  logic                             i_cfg_we,
    input  logic [c3rb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [c3rb_pkg::CFG_W-1:0]       i_cfg_data
);
    import c3rb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int MW = 2 * PIX_W;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(PIX_MAX);

    // configuration
    logic [CFG_W-1:0]  r_coef [3];
    logic [GEOM_W-1:0] r_frame_width;
    logic [GEOM_W-1:0] r_frame_height;
    logic [WW-1:0]     w_eff;
    logic [GEOM_W-1:0] h_eff;
    logic              geom_wr;

    // frame counters
    logic [CW-1:0]        r_in_col, n_in_col;
    logic [GEOM_W-1:0]    r_in_row, n_in_row;
    logic [CW-1:0]        r_out_col, n_out_col;
    logic [ROW_OUT_W-1:0] r_out_row, n_out_row;

    logic     accept, take, in_slot, emit;
    t_win_ctl ctl;

    // pipeline enables
    logic en1, en2, en3, en4, en5, en_out, move1;

    // stage 1: line memory read
    logic             r_s1_valid;
    logic             r_s1_wr;
    logic             r_s1_emit;
    logic [CW-1:0]    r_s1_addr;
    logic [PIX_W-1:0] r_s1_pix;
    t_win_ctl         r_s1_ctl;

    logic [MW-1:0] r_line_mem [MAX_WIDTH];
    logic [MW-1:0] r_rd_raw;
    logic [MW-1:0] r_fwd_data;
    logic          r_fwd_hit;
    logic [MW-1:0] rd;
    logic [MW-1:0] mem_wd;
    logic          mem_we;

    t_col cur;
    t_col r_col1, r_col2;
    t_col cols  [3];
    t_col win_n [3];

    // stages 2..5 and output
    logic                     r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    logic                     r_s2_last, r_s3_last, r_s4_last, r_s5_last;
    t_col                     r_win [3];
    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [RSUM_W-1:0] r_rsum [3];
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  q_rnd;
    logic [PIX_W-1:0]         pix_sat;
    logic                     r_out_valid;
    t_out_word                r_out_word;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0]      <= COEF_RESET;
            r_coef[1]      <= COEF_RESET;
            r_coef[2]      <= COEF_RESET;
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COEF_TOP:     r_coef[0]      <= i_cfg_data;
                CFG_COEF_MID:     r_coef[1]      <= i_cfg_data;
                CFG_COEF_BOT:     r_coef[2]      <= i_cfg_data;
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[GEOM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[GEOM_W-1:0];
                default: ;
            endcase
        end
    end

    assign geom_wr = i_cfg_we && ((i_cfg_index == CFG_FRAME_WIDTH) ||
                                  (i_cfg_index == CFG_FRAME_HEIGHT));

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = GEOM_W'(1);
        end else if (r_frame_height > GEOM_W'(HEIGHT_MAX)) begin
            h_eff = GEOM_W'(HEIGHT_MAX);
        end else begin
            h_eff = r_frame_height;
        end
    end

    // ---------------- counters ----------------
    assign accept  = i_in_valid && o_in_ready;
    assign in_slot = r_in_row < h_eff;
    assign take    = accept && !((i_in_word.op == OP_FLUSH) && in_slot);
    assign emit    = !((r_in_row == '0) || ((r_in_row == GEOM_W'(1)) && (r_in_col == '0)));

    always_comb begin
        ctl.c_first = (r_out_col == '0);
        ctl.c_last  = (WW'(r_out_col) == (w_eff - WW'(1)));
        ctl.r_first = (r_out_row == '0);
        ctl.r_last  = (GEOM_W'(r_out_row) == (h_eff - GEOM_W'(1)));
        ctl.last    = emit && ctl.c_last && ctl.r_last;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (geom_wr || (take && ctl.last)) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (take) begin
            if ((WW'(r_in_col) + WW'(1)) == w_eff) begin
                n_in_col = '0;
                n_in_row = r_in_row + GEOM_W'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (emit) begin
                if (ctl.c_last) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ROW_OUT_W'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
    end

    // ---------------- enables ----------------
    assign en_out     = !r_out_valid || i_out_ready;
    assign en5        = !r_s5_valid || en_out;
    assign en4        = !r_s4_valid || en5;
    assign en3        = !r_s3_valid || en4;
    assign en2        = !r_s2_valid || en3;
    assign en1        = !r_s1_valid || en2;
    assign move1      = r_s1_valid && en2;
    assign o_in_ready = en1;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (en1) begin
                r_s1_valid <= take;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid && r_s1_emit;
            end
            if (en3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (en4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (en5) begin
                r_s5_valid <= r_s4_valid;
            end
            if (en_out) begin
                r_out_valid <= r_s5_valid;
            end
        end
    end

    // ---------------- stage 1: line memory ----------------
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_wr   <= in_slot;
            r_s1_emit <= emit;
            r_s1_addr <= r_in_col;
            r_s1_pix  <= i_in_word.pixel_in;
            r_s1_ctl  <= ctl;
        end
    end

    // entry holds {older row, newer row} of one column
    assign rd     = r_fwd_hit ? r_fwd_data : r_rd_raw;
    assign mem_we = move1 && r_s1_wr;
    assign mem_wd = {rd[PIX_W-1:0], r_s1_pix};
    assign cur    = {r_s1_pix, rd[PIX_W-1:0], rd[MW-1:PIX_W]};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line_mem[r_s1_addr] <= mem_wd;
        end
        if (take) begin
            r_rd_raw   <= r_line_mem[r_in_col];
            r_fwd_hit  <= mem_we && (r_s1_addr == r_in_col);
            r_fwd_data <= mem_wd;
        end
    end

    // column shift and border replication
    always_comb begin
        cols[0] = r_s1_ctl.c_first ? r_col1 : r_col2;
        cols[1] = r_col1;
        cols[2] = r_s1_ctl.c_last ? r_col1 : cur;
        for (int j = 0; j < 3; j++) begin
            win_n[j] = cols[j];
            if (r_s1_ctl.r_first) begin
                win_n[j][0] = cols[j][1];
            end
            if (r_s1_ctl.r_last) begin
                win_n[j][2] = cols[j][1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move1) begin
            r_col2 <= r_col1;
            r_col1 <= cur;
        end
        if (en2) begin
            r_win     <= win_n;
            r_s2_last <= r_s1_ctl.last;
        end
    end

    // ---------------- stages 3..5: multiply and sum ----------------
    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i][j] <= $signed(r_coef[i][TAP_W*j +: TAP_W]) *
                                    $signed({1'b0, r_win[j][i]});
                end
            end
            r_s3_last <= r_s2_last;
        end
        if (en4) begin
            for (int i = 0; i < 3; i++) begin
                r_rsum[i] <= RSUM_W'(r_prod[i][0]) + RSUM_W'(r_prod[i][1]) +
                             RSUM_W'(r_prod[i][2]);
            end
            r_s4_last <= r_s3_last;
        end
        if (en5) begin
            r_sum     <= SUM_W'(r_rsum[0]) + SUM_W'(r_rsum[1]) + SUM_W'(r_rsum[2]);
            r_s5_last <= r_s4_last;
        end
    end

    // ---------------- round half to even, saturate ----------------
    if (COEF_FRAC_BITS == 0) begin : g_nofrac
        assign q_rnd = r_sum;
    end else begin : g_frac
        localparam logic [COEF_FRAC_BITS-1:0] HALF =
            COEF_FRAC_BITS'(1 << (COEF_FRAC_BITS - 1));
        logic signed [SUM_W-1:0]    q_sh;
        logic [COEF_FRAC_BITS-1:0] rem;
        logic                      up;
        assign q_sh  = r_sum >>> COEF_FRAC_BITS;
        assign rem   = r_sum[COEF_FRAC_BITS-1:0];
        assign up    = (rem > HALF) || ((rem == HALF) && q_sh[0]);
        assign q_rnd = q_sh + SUM_W'(up);
    end

    always_comb begin
        if (q_rnd[SUM_W-1]) begin
            pix_sat = '0;
        end else if (q_rnd > SAT_HI) begin
            pix_sat = '1;
        end else begin
            pix_sat = q_rnd[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_word.pixel_out  <= pix_sat;
            r_out_word.frame_last <= r_s5_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ---------------- assertions ----------------
    a_in_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WW'(r_in_col) < w_eff)
        else $error("input column outside frame width");

    a_out_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        GEOM_W'(r_out_row) < h_eff)
        else $error("output row outside frame height");

    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && ctl.last) |=>
            ((r_in_col == '0) && (r_in_row == '0) &&
             (r_out_col == '0) && (r_out_row == '0)))
        else $error("counters not restarted after last word of frame");

endmodule
